>>> rtl/gbn_pkg.sv
// shared types and constants of the go-back-n sender
package gbn_pkg;

    localparam int SEQ_W           = 32;
    localparam int MLEN_W          = 16;
    localparam int LEN_W           = 11;
    localparam int CFG_ADDR_W      = 1;
    localparam int MAX_SEGMENT     = 4;
    localparam int WINDOW_SEGMENTS = 4;
    localparam int WINDOW_BYTES    = WINDOW_SEGMENTS * MAX_SEGMENT;
    localparam int SEG_CNT_W       = $clog2(WINDOW_SEGMENTS + 1);
    localparam int CMD_DEPTH       = 2;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_INIT_SEQ = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_MSG_LEN  = CFG_ADDR_W'(1);

    // reset value of the message length
    localparam logic [MLEN_W-1:0] MSG_LEN_RESET = MLEN_W'(12);

    typedef enum logic [1:0] {
        LINK_WAIT   = 2'd0,
        LINK_EST    = 2'd1,
        LINK_FIN    = 2'd2,
        LINK_CLOSED = 2'd3
    } link_t;

    typedef enum logic [1:0] {
        PKT_ACK  = 2'd0,
        PKT_DATA = 2'd1,
        PKT_FIN  = 2'd2
    } pkt_type_t;

    // work handed from the classifier to the emitter
    typedef enum logic [1:0] {
        OP_STATUS  = 2'd0,
        OP_SINGLE  = 2'd1,
        OP_ACK_WIN = 2'd2,
        OP_WIN     = 2'd3
    } op_t;

    typedef struct packed {
        op_t              op;
        pkt_type_t        ptype;
        logic [SEQ_W-1:0] seq;
        logic [SEQ_W-1:0] ack;
        link_t            link;
        logic             seq_wr;
        logic [SEQ_W-1:0] seq_val;
        logic [SEQ_W-1:0] limit;
    } cmd_t;

    // configuration as seen by the emitter
    typedef struct packed {
        logic [SEQ_W-1:0]  init_p1;
        logic [MLEN_W-1:0] msg_len;
        logic              seq_load;
        logic [SEQ_W-1:0]  seq_load_val;
    } cfg_view_t;

    // emitter status back to the classifier
    typedef struct packed {
        logic             idle;
        logic [SEQ_W-1:0] next_seq;
    } bk_stat_t;

    typedef struct packed {
        logic              sent;
        pkt_type_t         ptype;
        logic [SEQ_W-1:0]  seq;
        logic [SEQ_W-1:0]  ack;
        logic [MLEN_W-1:0] offset;
        logic [LEN_W-1:0]  length;
        link_t             link;
        logic              last;
    } result_t;

endpackage

>>> rtl/gbn_rx_if.sv
// received packet and timeout channel
interface gbn_rx_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic                      syn_flag;
    logic                      ack_flag;
    logic [gbn_pkg::SEQ_W-1:0] peer_sequence;
    logic [gbn_pkg::SEQ_W-1:0] ack_number;

    modport source (
        output valid, kind, syn_flag, ack_flag, peer_sequence, ack_number,
        input  ready
    );
    modport sink (
        input  valid, kind, syn_flag, ack_flag, peer_sequence, ack_number,
        output ready
    );
endinterface

>>> rtl/gbn_tx_if.sv
// result channel
interface gbn_tx_if;
    logic                       valid;
    logic                       ready;
    logic                       sent;
    logic [1:0]                 packet_type;
    logic [gbn_pkg::SEQ_W-1:0]  out_sequence;
    logic [gbn_pkg::SEQ_W-1:0]  out_ack;
    logic [gbn_pkg::MLEN_W-1:0] payload_offset;
    logic [gbn_pkg::LEN_W-1:0]  payload_length;
    logic [1:0]                 link_state;
    logic                       last;

    modport source (
        output valid, sent, packet_type, out_sequence, out_ack, payload_offset,
               payload_length, link_state, last,
        input  ready
    );
    modport sink (
        input  valid, sent, packet_type, out_sequence, out_ack, payload_offset,
               payload_length, link_state, last,
        output ready
    );
endinterface

>>> rtl/gbn_cfg_if.sv
// configuration write channel
interface gbn_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [gbn_pkg::CFG_ADDR_W-1:0] addr;
    logic [gbn_pkg::SEQ_W-1:0]      data;

    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

>>> rtl/gbn_front.sv
// classifier: takes received packets and timeouts, keeps link state, issues commands
module gbn_front (
    input  logic                clk,
    input  logic                rst_n,
    gbn_rx_if.sink              rx,
    gbn_cfg_if.sink             cfg,
    input  gbn_pkg::bk_stat_t   bk_stat,
    input  logic                q_empty,
    output logic                push,
    output gbn_pkg::cmd_t       cmd,
    output gbn_pkg::cfg_view_t  cfg_view
);
    import gbn_pkg::*;

    logic [SEQ_W-1:0]  init_p1_reg;
    logic [SEQ_W-1:0]  end_p1_reg;
    logic [MLEN_W-1:0] msg_len_reg;
    logic [SEQ_W-1:0]  base_reg;
    logic [SEQ_W-1:0]  base_next;
    link_t             link_reg;
    link_t             link_next;
    logic              cfg_wr;
    logic              ack_valid;
    logic [SEQ_W-1:0]  nseq;

    assign nseq      = bk_stat.next_seq;
    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid;

    // one beat at a time: the emitter must have drained all earlier work
    assign rx.ready = q_empty && bk_stat.idle;
    assign push     = rx.valid && rx.ready;

    assign ack_valid = rx.ack_flag && (rx.ack_number > base_reg)
                       && (rx.ack_number <= nseq);

    // classify the beat against the link state
    always_comb
    begin
        link_next   = link_reg;
        base_next   = base_reg;
        cmd.op      = OP_STATUS;
        cmd.ptype   = PKT_ACK;
        cmd.seq     = '0;
        cmd.ack     = '0;
        cmd.seq_wr  = 1'b0;
        cmd.seq_val = '0;
        cmd.limit   = base_reg + SEQ_W'(WINDOW_BYTES);
        if (rx.kind)
        begin
            unique case (link_reg)
                LINK_EST:
                begin
                    cmd.op      = OP_WIN;
                    cmd.seq_wr  = 1'b1;
                    cmd.seq_val = base_reg + SEQ_W'(1);
                end
                LINK_FIN:
                begin
                    cmd.op    = OP_SINGLE;
                    cmd.ptype = PKT_FIN;
                    cmd.seq   = nseq - SEQ_W'(1);
                end
                LINK_WAIT, LINK_CLOSED:
                begin
                    link_next = LINK_CLOSED;
                end
                default:
                begin
                    link_next = LINK_CLOSED;
                end
            endcase
        end
        else
        begin
            unique case (link_reg)
                LINK_WAIT:
                begin
                    if (rx.syn_flag && rx.ack_flag && (rx.ack_number == nseq))
                    begin
                        link_next = LINK_EST;
                        cmd.op    = OP_ACK_WIN;
                        cmd.ptype = PKT_ACK;
                        cmd.seq   = nseq;
                        cmd.ack   = rx.peer_sequence + SEQ_W'(1);
                    end
                end
                LINK_EST:
                begin
                    if (ack_valid)
                    begin
                        base_next = rx.ack_number - SEQ_W'(1);
                        if (rx.ack_number == end_p1_reg)
                        begin
                            link_next   = LINK_FIN;
                            cmd.op      = OP_SINGLE;
                            cmd.ptype   = PKT_FIN;
                            cmd.seq     = nseq;
                            cmd.seq_wr  = 1'b1;
                            cmd.seq_val = nseq + SEQ_W'(1);
                        end
                        else
                        begin
                            cmd.op    = OP_WIN;
                            cmd.limit = rx.ack_number + SEQ_W'(WINDOW_BYTES - 1);
                        end
                    end
                end
                LINK_FIN:
                begin
                    if (rx.ack_flag && (rx.ack_number == nseq))
                    begin
                        link_next = LINK_CLOSED;
                    end
                end
                LINK_CLOSED:
                begin
                    link_next = link_reg;
                end
                default:
                begin
                    link_next = link_reg;
                end
            endcase
        end
        cmd.link = link_next;
    end

    // configuration view for the emitter
    always_comb
    begin
        cfg_view.init_p1      = init_p1_reg;
        cfg_view.msg_len      = msg_len_reg;
        cfg_view.seq_load     = cfg_wr && (cfg.addr == REG_INIT_SEQ);
        cfg_view.seq_load_val = cfg.data + SEQ_W'(1);
    end

    // link state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg    <= LINK_WAIT;
            base_reg    <= '0;
            init_p1_reg <= SEQ_W'(1);
            msg_len_reg <= MSG_LEN_RESET;
            end_p1_reg  <= SEQ_W'(MSG_LEN_RESET) + SEQ_W'(1);
        end
        else
        begin
            if (cfg_wr && (cfg.addr == REG_INIT_SEQ))
            begin
                init_p1_reg <= cfg.data + SEQ_W'(1);
                base_reg    <= cfg.data;
                end_p1_reg  <= cfg.data + SEQ_W'(msg_len_reg) + SEQ_W'(1);
            end
            else if (cfg_wr && (cfg.addr == REG_MSG_LEN))
            begin
                msg_len_reg <= cfg.data[MLEN_W-1:0];
                end_p1_reg  <= init_p1_reg + SEQ_W'(cfg.data[MLEN_W-1:0]);
            end
            else if (push)
            begin
                link_reg <= link_next;
                base_reg <= base_next;
            end
        end
    end

endmodule

>>> rtl/gbn_cmd_fifo.sv
// short command queue between classifier and emitter
module gbn_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  gbn_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          empty,
    output gbn_pkg::cmd_t head
);
    import gbn_pkg::*;

    localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    cmd_t             entry_reg [CMD_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign empty   = (count_reg == '0);
    assign do_push = push && (count_reg != CNT_W'(CMD_DEPTH));
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0
                              : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0
                              : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

>>> rtl/gbn_back.sv
// emitter: turns commands into result beats, one segment a cycle while tx is ready
module gbn_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  gbn_pkg::cmd_t      q_head,
    output logic               pop,
    input  gbn_pkg::cfg_view_t cfg_view,
    output gbn_pkg::bk_stat_t  bk_stat,
    gbn_tx_if.source           tx
);
    import gbn_pkg::*;

    typedef enum logic {
        B_IDLE,
        B_SEG
    } bstate_t;

    bstate_t            state_reg;
    logic [SEQ_W-1:0]   nseq_reg;
    logic [SEQ_W-1:0]   limit_reg;
    link_t              link_reg;
    logic [SEG_CNT_W-1:0] segs_reg;
    result_t            hold_reg;
    logic               hold_valid_reg;
    result_t            out_reg;
    logic               out_valid_reg;

    logic               out_free;
    logic               out_load;
    logic [SEQ_W-1:0]   off;
    logic [MLEN_W-1:0]  rem;
    logic [LEN_W-1:0]   seg_len;
    logic               seg_ok;
    result_t            seg_res;
    result_t            status_res;
    result_t            single_res;
    result_t            ack_res;
    result_t            hold_last;

    assign out_free = !out_valid_reg || tx.ready;
    assign pop      = (state_reg == B_IDLE) && !q_empty && out_free;

    assign bk_stat.idle     = (state_reg == B_IDLE);
    assign bk_stat.next_seq = nseq_reg;

    // next segment of the window
    assign off     = nseq_reg - cfg_view.init_p1;
    assign rem     = cfg_view.msg_len - off[MLEN_W-1:0];
    assign seg_len = (rem > MLEN_W'(MAX_SEGMENT)) ? LEN_W'(MAX_SEGMENT) : rem[LEN_W-1:0];
    assign seg_ok  = (segs_reg != SEG_CNT_W'(WINDOW_SEGMENTS))
                     && (off < SEQ_W'(cfg_view.msg_len))
                     && (nseq_reg < limit_reg);

    // output register takes a new beat this cycle
    assign out_load = (pop && ((q_head.op == OP_STATUS) || (q_head.op == OP_SINGLE)))
                      || ((state_reg == B_SEG) && out_free && (!seg_ok || hold_valid_reg));

    always_comb
    begin
        seg_res        = '0;
        seg_res.sent   = 1'b1;
        seg_res.ptype  = PKT_DATA;
        seg_res.seq    = nseq_reg;
        seg_res.offset = off[MLEN_W-1:0];
        seg_res.length = seg_len;
        seg_res.link   = link_reg;

        status_res      = '0;
        status_res.link = link_reg;
        status_res.last = 1'b1;

        single_res       = '0;
        single_res.sent  = (q_head.op == OP_SINGLE);
        single_res.ptype = q_head.ptype;
        single_res.seq   = q_head.seq;
        single_res.link  = q_head.link;
        single_res.last  = 1'b1;

        ack_res       = '0;
        ack_res.sent  = 1'b1;
        ack_res.ptype = PKT_ACK;
        ack_res.seq   = q_head.seq;
        ack_res.ack   = q_head.ack;
        ack_res.link  = q_head.link;

        hold_last      = hold_reg;
        hold_last.last = 1'b1;
    end

    // sequencer, hold stage and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            nseq_reg       <= SEQ_W'(1);
            limit_reg      <= '0;
            link_reg       <= LINK_WAIT;
            segs_reg       <= '0;
            hold_reg       <= '0;
            hold_valid_reg <= 1'b0;
            out_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && tx.ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_view.seq_load)
            begin
                nseq_reg <= cfg_view.seq_load_val;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (pop)
                    begin
                        link_reg  <= q_head.link;
                        limit_reg <= q_head.limit;
                        segs_reg  <= '0;
                        if (q_head.seq_wr)
                        begin
                            nseq_reg <= q_head.seq_val;
                        end
                        unique case (q_head.op)
                            OP_STATUS, OP_SINGLE:
                            begin
                                out_reg       <= single_res;
                                out_valid_reg <= 1'b1;
                            end
                            OP_ACK_WIN:
                            begin
                                hold_reg       <= ack_res;
                                hold_valid_reg <= 1'b1;
                                state_reg      <= B_SEG;
                            end
                            OP_WIN:
                            begin
                                state_reg <= B_SEG;
                            end
                            default:
                            begin
                                state_reg <= B_IDLE;
                            end
                        endcase
                    end
                end
                B_SEG:
                begin
                    if (out_free)
                    begin
                        if (seg_ok)
                        begin
                            // earlier beat leaves, new segment waits for its last flag
                            if (hold_valid_reg)
                            begin
                                out_reg       <= hold_reg;
                                out_valid_reg <= 1'b1;
                            end
                            hold_reg       <= seg_res;
                            hold_valid_reg <= 1'b1;
                            nseq_reg       <= nseq_reg + SEQ_W'(seg_len);
                            segs_reg       <= segs_reg + SEG_CNT_W'(1);
                        end
                        else
                        begin
                            // window closed: flush the held beat as the final one
                            if (hold_valid_reg)
                            begin
                                out_reg <= hold_last;
                            end
                            else
                            begin
                                out_reg <= status_res;
                            end
                            out_valid_reg  <= 1'b1;
                            hold_valid_reg <= 1'b0;
                            state_reg      <= B_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    // result channel
    assign tx.valid          = out_valid_reg;
    assign tx.sent           = out_reg.sent;
    assign tx.packet_type    = out_reg.ptype;
    assign tx.out_sequence   = out_reg.seq;
    assign tx.out_ack        = out_reg.ack;
    assign tx.payload_offset = out_reg.offset;
    assign tx.payload_length = out_reg.length;
    assign tx.link_state     = out_reg.link;
    assign tx.last           = out_reg.last;

endmodule

>>> rtl/go_back_n_sender_fsm.sv
// top level of the go-back-n sender with handshake
//
//  channel  dir  handshake     beat
//  rx       in   valid/ready   kind, syn_flag, ack_flag, peer_sequence, ack_number
//  tx       out  valid/ready   sent, packet_type, out_sequence, out_ack,
//                              payload_offset, payload_length, link_state, last
//  cfg      in   valid/ready   addr (0 initial_sequence, 1 message_length), data
//
//  An rx beat is classified in the cycle it is taken and the emitter picks it up
//  from the command queue. A beat with no window gives its one tx beat at once;
//  a window beat gives one segment a cycle while tx is ready, and a final flush.
//  The next rx beat is taken once the emitter has drained the previous one, which
//  may leave its final beat still waiting in the tx register.
//  rst_n clears the link to awaiting SYN-ACK with initial sequence 0 and length 12.
//  cfg is always ready; tx stalls hold the emitter, and rx waits behind it.
module go_back_n_sender_fsm (
    input  logic clk,
    input  logic rst_n,
    gbn_rx_if.sink   rx,
    gbn_tx_if.source tx,
    gbn_cfg_if.sink  cfg
);
    import gbn_pkg::*;

    logic      push;
    logic      pop;
    logic      q_empty;
    cmd_t      cmd;
    cmd_t      q_head;
    cfg_view_t cfg_view;
    bk_stat_t  bk_stat;

    // classifier
    gbn_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx),
        .cfg      (cfg),
        .bk_stat  (bk_stat),
        .q_empty  (q_empty),
        .push     (push),
        .cmd      (cmd),
        .cfg_view (cfg_view)
    );

    // command queue
    gbn_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (cmd),
        .pop      (pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    // emitter
    gbn_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .pop      (pop),
        .cfg_view (cfg_view),
        .bk_stat  (bk_stat),
        .tx       (tx)
    );

endmodule

>>> test/go_back_n_sender_fsm_tb.sv
// testbench for the go-back-n sender: handshake, sliding window, rewind and teardown
`timescale 1ns / 1ps

module go_back_n_sender_fsm_tb;
    import gbn_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int IDLE_PCT      = 35;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 4;
    localparam int PHASE_ITEMS   = 30;

    localparam logic KIND_PACKET  = 1'b0;
    localparam logic KIND_TIMEOUT = 1'b1;

    typedef struct packed {
        logic             kind;
        logic             syn;
        logic             ack;
        logic [SEQ_W-1:0] peer_seq;
        logic [SEQ_W-1:0] ack_num;
    } rx_beat_t;

    logic clk;
    logic rst_n;

    gbn_rx_if  rx_bus ();
    gbn_tx_if  tx_bus ();
    gbn_cfg_if cfg_bus ();

    go_back_n_sender_fsm dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_bus),
        .tx    (tx_bus),
        .cfg   (cfg_bus)
    );

    // own copy of the link state and settings
    logic [SEQ_W-1:0]  m_init;
    logic [MLEN_W-1:0] m_len;
    link_t             m_link;
    logic [SEQ_W-1:0]  m_next;
    logic [SEQ_W-1:0]  m_base;
    logic [SEQ_W-1:0]  m_peer;

    result_t reply[$];
    result_t awaited[$];
    result_t want;
    int      errors;
    int      stall_cycles;
    bit      steady;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // receiver back-pressure
    initial
    begin
        tx_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tx_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic result_t packet_beat(input pkt_type_t ptype,
                                            input logic [SEQ_W-1:0] seq, ack,
                                            input logic [MLEN_W-1:0] offset,
                                            input logic [LEN_W-1:0] length);
        result_t r;
        r        = '0;
        r.sent   = 1'b1;
        r.ptype  = ptype;
        r.seq    = seq;
        r.ack    = ack;
        r.offset = offset;
        r.length = length;
        return r;
    endfunction

    // data segments from next_seq up to the window edge or the message end
    task automatic fill_window();
        logic [SEQ_W-1:0] limit;
        logic [SEQ_W-1:0] off;
        logic [SEQ_W-1:0] len;
        int               segs;
        limit = m_base + SEQ_W'(WINDOW_BYTES);
        segs  = 0;
        while (segs < WINDOW_SEGMENTS)
        begin
            off = m_next - m_init - 32'd1;
            if (off >= SEQ_W'(m_len) || m_next >= limit)
                break;
            len = SEQ_W'(m_len) - off;
            if (len > SEQ_W'(MAX_SEGMENT))
                len = SEQ_W'(MAX_SEGMENT);
            reply.push_back(packet_beat(PKT_DATA, m_next, '0, off[MLEN_W-1:0],
                                        len[LEN_W-1:0]));
            m_next = m_next + len;
            segs++;
        end
    endtask

    // beats the sender gives for one accepted rx beat
    task automatic sender_reaction(input rx_beat_t b);
        result_t status;
        reply.delete();
        if (b.kind == KIND_TIMEOUT)
        begin
            case (m_link)
                LINK_EST:
                begin
                    m_next = m_base + 32'd1;
                    fill_window();
                end
                LINK_FIN: reply.push_back(packet_beat(PKT_FIN, m_next - 32'd1, '0, '0, '0));
                default:  m_link = LINK_CLOSED;
            endcase
        end
        else
        begin
            case (m_link)
                LINK_WAIT:
                    if (b.syn && b.ack && b.ack_num == m_next)
                    begin
                        m_peer = b.peer_seq + 32'd1;
                        m_link = LINK_EST;
                        reply.push_back(packet_beat(PKT_ACK, m_next, m_peer, '0, '0));
                        fill_window();
                    end
                LINK_EST:
                    if (b.ack && b.ack_num > m_base && b.ack_num <= m_next)
                    begin
                        m_base = b.ack_num - 32'd1;
                        if (m_base == m_init + SEQ_W'(m_len))
                        begin
                            reply.push_back(packet_beat(PKT_FIN, m_next, '0, '0, '0));
                            m_link = LINK_FIN;
                            m_next = m_next + 32'd1;
                        end
                        else
                            fill_window();
                    end
                LINK_FIN:
                    if (b.ack && b.ack_num == m_next)
                        m_link = LINK_CLOSED;
                default: ;
            endcase
        end
        // nothing sent: one status beat
        if (reply.size() == 0)
        begin
            status = '0;
            reply.push_back(status);
        end
        foreach (reply[i])
        begin
            reply[i].link = m_link;
            reply[i].last = (i == reply.size() - 1);
            awaited.push_back(reply[i]);
        end
    endtask

    function automatic void check_field(input string name, input logic [SEQ_W-1:0] want_v,
                                        input logic [SEQ_W-1:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            errors = errors + 1;
        end
    endfunction

    // compare each tx beat with the oldest awaited one
    always @(posedge clk)
    begin
        if (rst_n && tx_bus.valid && tx_bus.ready)
        begin
            if (awaited.size() == 0)
            begin
                $error("tx beat with nothing awaited");
                errors = errors + 1;
            end
            else
            begin
                want = awaited.pop_front();
                check_field("sent", SEQ_W'(want.sent), SEQ_W'(tx_bus.sent));
                check_field("packet_type", SEQ_W'(want.ptype), SEQ_W'(tx_bus.packet_type));
                check_field("out_sequence", want.seq, tx_bus.out_sequence);
                check_field("out_ack", want.ack, tx_bus.out_ack);
                check_field("payload_offset", SEQ_W'(want.offset),
                            SEQ_W'(tx_bus.payload_offset));
                check_field("payload_length", SEQ_W'(want.length),
                            SEQ_W'(tx_bus.payload_length));
                check_field("link_state", SEQ_W'(want.link), SEQ_W'(tx_bus.link_state));
                check_field("last", SEQ_W'(want.last), SEQ_W'(tx_bus.last));
            end
        end
    end

    // cycles without any beat on any channel
    always @(posedge clk)
    begin
        if ((rx_bus.valid && rx_bus.ready) || (tx_bus.valid && tx_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("go_back_n_sender_fsm test failed");
        $finish;
    end

    function automatic rx_beat_t pkt(input logic syn, ack, input logic [SEQ_W-1:0] ack_num);
        rx_beat_t b;
        b.kind     = KIND_PACKET;
        b.syn      = syn;
        b.ack      = ack;
        b.peer_seq = $urandom;
        b.ack_num  = ack_num;
        return b;
    endfunction

    function automatic rx_beat_t timeout_beat();
        rx_beat_t b;
        b          = pkt(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
        b.kind     = KIND_TIMEOUT;
        return b;
    endfunction

    // mostly acks inside the window, with timeouts and stray packets
    function automatic rx_beat_t window_beat();
        rx_beat_t         b;
        logic [SEQ_W-1:0] span;
        int               pick;
        b    = pkt(1'($urandom_range(0, 1)), 1'b1, $urandom);
        span = m_next - m_base;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            b.kind = KIND_TIMEOUT;
        else if (pick < 30)
        begin
            b.ack = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 1))
                b.ack_num = m_base + $urandom_range(0, 20);
        end
        else if (span != 0 && span <= 64)
            b.ack_num = m_base + 32'd1 + $urandom_range(0, span - 1);
        // acking the final byte would start teardown, keep the link open
        if (b.ack_num - 32'd1 == m_init + SEQ_W'(m_len))
            b.ack_num = m_base;
        return b;
    endfunction

    // one rx beat, with random gaps ahead of it
    task automatic send_item(input rx_beat_t b);
        if (!steady)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                rx_bus.valid <= 1'b0;
                @(posedge clk);
            end
        end
        rx_bus.valid         <= 1'b1;
        rx_bus.kind          <= b.kind;
        rx_bus.syn_flag      <= b.syn;
        rx_bus.ack_flag      <= b.ack;
        rx_bus.peer_sequence <= b.peer_seq;
        rx_bus.ack_number    <= b.ack_num;
        do
            @(posedge clk);
        while (!rx_bus.ready);
        sender_reaction(b);
    endtask

    // hold rx until every awaited beat has come out
    task automatic settle();
        rx_bus.valid <= 1'b0;
        while (awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [SEQ_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.addr  <= idx;
        cfg_bus.data  <= data;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        if (idx == REG_INIT_SEQ)
        begin
            m_init = data;
            m_next = data + 32'd1;
            m_base = data;
        end
        else
            m_len = data[MLEN_W-1:0];
        @(posedge clk);
    endtask

    // length register with junk in the unused upper bits
    task automatic set_length(input logic [MLEN_W-1:0] len);
        write_reg(REG_MSG_LEN, {16'($urandom), len});
    endtask

    task automatic random_settings();
        logic [SEQ_W-1:0]  init_v;
        logic [MLEN_W-1:0] len_v;
        case ($urandom_range(0, 5))
            0:       init_v = '0;
            1:       init_v = '1;
            2:       init_v = 32'hFFFF_FFF0;
            default: init_v = $urandom;
        endcase
        case ($urandom_range(0, 7))
            0:       len_v = '0;
            1:       len_v = '1;
            2:       len_v = 16'd1;
            3:       len_v = MLEN_W'($urandom);
            default: len_v = MLEN_W'($urandom_range(2, 48));
        endcase
        if ($urandom_range(0, 3) != 0)
            write_reg(REG_INIT_SEQ, init_v);
        if ($urandom_range(0, 3) != 0)
            set_length(len_v);
    endtask

    // wrong replies, then the handshake across the sequence wrap
    task automatic test_handshake();
        rx_beat_t b;
        send_item(pkt(1'b1, 1'b0, m_next));
        send_item(pkt(1'b0, 1'b1, m_next));
        send_item(pkt(1'b1, 1'b1, m_next + 32'd1));
        send_item(pkt(1'b0, 1'b0, m_next));
        settle();
        write_reg(REG_INIT_SEQ, '1);
        set_length('1);
        b          = pkt(1'b1, 1'b1, m_next);
        b.peer_seq = '1;
        send_item(b);
        send_item(timeout_beat());
    endtask

    // invalid acks, window slide, empty rewind and a short tail segment
    task automatic test_window_directed();
        settle();
        write_reg(REG_INIT_SEQ, 32'd1000);
        send_item(timeout_beat());
        send_item(pkt(1'b0, 1'b1, m_base));
        send_item(pkt(1'b0, 1'b1, m_next + 32'd1));
        send_item(pkt(1'b0, 1'b0, m_next));
        send_item(pkt(1'b1, 1'b1, m_base + 32'd5));
        send_item(pkt(1'b0, 1'b1, m_next));
        settle();
        set_length('0);
        send_item(timeout_beat());
        settle();
        set_length(16'd18);
        write_reg(REG_INIT_SEQ, 32'd1000);
        send_item(timeout_beat());
        send_item(pkt(1'b0, 1'b1, m_next));
    endtask

    task automatic test_random_window();
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            random_settings();
            repeat (PHASE_ITEMS) send_item(window_beat());
        end
    endtask

    // both sides without gaps
    task automatic test_back_to_back();
        settle();
        random_settings();
        steady = 1'b1;
        repeat (PHASE_ITEMS) send_item(window_beat());
        settle();
        steady = 1'b0;
    endtask

    // ack to the end, FIN resends, close and the closed link
    task automatic test_teardown();
        int guard;
        settle();
        write_reg(REG_INIT_SEQ, $urandom_range(0, 32'h7FFF_FFFF));
        set_length(MLEN_W'($urandom_range(5, 40)));
        guard = 0;
        while (m_link == LINK_EST && guard < 40)
        begin
            send_item(pkt(1'($urandom_range(0, 1)), 1'b1, m_next));
            guard++;
        end
        send_item(timeout_beat());
        send_item(pkt(1'b0, 1'b1, m_next + 32'd1));
        send_item(pkt(1'b1, 1'b0, m_next));
        send_item(timeout_beat());
        send_item(pkt(1'b0, 1'b1, m_next));
        send_item(pkt(1'b1, 1'b1, m_next));
        send_item(timeout_beat());
    endtask

    // main sequence
    initial
    begin
        m_init = '0;
        m_len  = MSG_LEN_RESET;
        m_link = LINK_WAIT;
        m_next = 32'd1;
        m_base = '0;
        m_peer = '0;
        steady = 1'b0;

        rst_n                <= 1'b0;
        rx_bus.valid         <= 1'b0;
        rx_bus.kind          <= KIND_PACKET;
        rx_bus.syn_flag      <= 1'b0;
        rx_bus.ack_flag      <= 1'b0;
        rx_bus.peer_sequence <= '0;
        rx_bus.ack_number    <= '0;
        cfg_bus.valid        <= 1'b0;
        cfg_bus.addr         <= REG_INIT_SEQ;
        cfg_bus.data         <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // a timeout while awaiting the reply would close the link for good,
        // so that state only sees packets; the closed link sees timeouts
        test_handshake();
        test_window_directed();
        test_random_window();
        test_back_to_back();
        test_teardown();
        settle();

        if (errors == 0)
            $display("go_back_n_sender_fsm test passed");
        else
            $display("go_back_n_sender_fsm test failed");
        $finish;
    end

endmodule
